>>> hw/rtl/fla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fla_pkg: shared types and constants of the free-list slot allocator
// Pool size, field widths, request/response transaction layouts and the
// codes that travel on the command and status fields.
// ----------------------------------------------------------------------------
package fla_pkg;

    // Pool geometry
    localparam int SLOTS    = 64;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = $clog2(SLOTS + 1);

    // Field widths of the transactions
    localparam int CMD_W    = 1;
    localparam int HANDLE_W = 8;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;
    localparam int INUSE_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FREED     = 2'd2,
        ST_FOREIGN   = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [HANDLE_W-1:0] handle;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [SLOT_W-1:0]  slot;
        logic [INUSE_W-1:0] in_use;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture request, read link entry of current head
        logic exec;   // update list and count, load response register
    } ctl_t;

endpackage : fla_pkg
`default_nettype wire

>>> hw/rtl/fla_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fla_ctrl: request sequencer
// Two-state machine (accept/read, then execute) plus the response valid
// flag; issues load and exec commands to the datapath.
// ----------------------------------------------------------------------------
module fla_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output fla_pkg::ctl_t    ctl
);
    import fla_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   take;

    // Response register is free now or drains this cycle
    assign req_ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign take      = req_valid && req_ready;
    assign ctl.load  = take;
    assign ctl.exec  = (state_reg == S_EXEC);
    assign rsp_valid = rsp_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                    state_next = S_EXEC;
            end
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Response valid: set on execute, cleared when taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        if (ctl.exec)
            rsp_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule : fla_ctrl
`default_nettype wire

>>> hw/rtl/fla_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fla_dp: free-list datapath
// Head pointer, allocated count, link memory with per-entry written bits
// (unwritten entries read as their reset link) and the response register.
// ----------------------------------------------------------------------------
module fla_dp (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire fla_pkg::ctl_t ctl,
    input  wire fla_pkg::req_t req,
    output fla_pkg::rsp_t      rsp
);
    import fla_pkg::*;

    localparam int LW = IDX_W + 1;   // link word: {valid, index}

    // Link memory (no reset) and its written flags
    logic [LW-1:0]    link_mem [SLOTS];
    logic [SLOTS-1:0] written_reg;

    // Captured request and registered link read
    cmd_t                cmd_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [LW-1:0]       rd_word_reg;
    logic                rd_written_reg;

    // List state
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic             head_vld_reg;
    logic             head_vld_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    rsp_t rsp_reg;
    rsp_t rsp_next;

    logic             free_hit;
    logic             alloc_hit;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] pop_idx;
    logic             pop_vld;

    assign free_hit  = (cmd_reg == CMD_FREE)
                       && ((HANDLE_W + 1)'(handle_reg) < (HANDLE_W + 1)'(SLOTS));
    assign alloc_hit = (cmd_reg == CMD_ALLOC) && head_vld_reg;
    assign wr_addr   = handle_reg[IDX_W-1:0];

    // Successor of the head: stored link, or the reset link if never written
    always_comb
    begin
        if (rd_written_reg)
        begin
            pop_idx = rd_word_reg[IDX_W-1:0];
            pop_vld = rd_word_reg[IDX_W];
        end
        else
        begin
            pop_idx = head_reg + IDX_W'(1);
            pop_vld = (head_reg != IDX_W'(SLOTS - 1));
        end
    end

    // List update and response
    always_comb
    begin
        head_next     = head_reg;
        head_vld_next = head_vld_reg;
        cnt_next      = cnt_reg;
        rsp_next      = '0;
        if (alloc_hit)
        begin
            head_next       = pop_idx;
            head_vld_next   = pop_vld;
            if (cnt_reg != CNT_W'(SLOTS))
                cnt_next = cnt_reg + CNT_W'(1);
            rsp_next.status = ST_ALLOCATED;
            rsp_next.slot   = SLOT_W'(head_reg);
        end
        else if (free_hit)
        begin
            head_next       = wr_addr;
            head_vld_next   = 1'b1;
            if (cnt_reg != '0)
                cnt_next = cnt_reg - CNT_W'(1);
            rsp_next.status = ST_FREED;
        end
        else if (cmd_reg == CMD_ALLOC)
            rsp_next.status = ST_EMPTY;
        else
            rsp_next.status = ST_FOREIGN;
        rsp_next.in_use = INUSE_W'(cnt_next);
    end

    // Link memory: push writes on execute, head read on accept
    always_ff @(posedge clk)
    begin
        if (ctl.exec && free_hit)
            link_mem[wr_addr] <= {head_vld_reg, head_reg};
        if (ctl.load)
            rd_word_reg <= link_mem[head_reg];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg    <= req.cmd;
            handle_reg <= req.handle;
        end
        if (ctl.exec)
            rsp_reg <= rsp_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
            head_reg       <= '0;
            head_vld_reg   <= 1'b1;
            cnt_reg        <= '0;
        end
        else
        begin
            if (ctl.load)
                rd_written_reg <= written_reg[head_reg];
            if (ctl.exec)
            begin
                if (free_hit)
                    written_reg[wr_addr] <= 1'b1;
                head_reg     <= head_next;
                head_vld_reg <= head_vld_next;
                cnt_reg      <= cnt_next;
            end
        end
    end

    assign rsp = rsp_reg;

endmodule : fla_dp
`default_nettype wire

>>> hw/rtl/free_list_slot_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// free_list_slot_allocator: LIFO linked free-list slot allocator
// Allocate pops the head slot, free pushes an in-pool handle; one response
// per request with status, slot and the allocated count.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_ready  | fla_pkg::req_t {cmd, handle}
//   rsp     | out       | rsp_valid/rsp_ready  | fla_pkg::rsp_t {status, slot, in_use}
//
// A request is accepted together with a link memory read, then the list
// update loads the response register. A new request is not accepted until
// the previous one has executed, as each request makes a single synchronous
// read of the link memory. Response becomes valid once the execute state
// has loaded the response register; the next request is accepted at the
// edge that takes it or later. Reset clears head, count and written flags at
// once; no clearing pass. A stalled response blocks the next acceptance.
// ----------------------------------------------------------------------------
module free_list_slot_allocator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire fla_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output fla_pkg::rsp_t      rsp
);
    import fla_pkg::*;

    ctl_t ctl;

    fla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctl       (ctl)
    );

    fla_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .req   (req),
        .rsp   (rsp)
    );

endmodule : free_list_slot_allocator
`default_nettype wire

>>> hw/rtl/fla_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fla_checker: port-level checks of the slot allocator
// Watches the request and response channels and the timing between them.
// ----------------------------------------------------------------------------
module fla_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    input  wire logic          req_ready,
    input  wire fla_pkg::req_t req,
    input  wire logic          rsp_valid,
    input  wire logic          rsp_ready,
    input  wire fla_pkg::rsp_t rsp
);
    import fla_pkg::*;

    // Block is busy in the cycle after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("req_ready high right after a request transaction");

    // Every request gets its response once the execute state has loaded it
    a_rsp_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |-> ##2 rsp_valid)
        else $error("response missing two cycles after request");

    // Out-of-pool handle is reported foreign
    a_foreign: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req.cmd == CMD_FREE
         && (HANDLE_W + 1)'(req.handle) >= (HANDLE_W + 1)'(SLOTS))
        |-> ##2 (rsp.status == ST_FOREIGN))
        else $error("foreign handle not reported as foreign");

    // Stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed or dropped");

endmodule : fla_checker

bind free_list_slot_allocator fla_checker u_fla_checker (.*);
`default_nettype wire
